// ===== src/u8san_pkg.sv =====
// shared types, constants and lead byte decoding for the utf8 sanitizer
package u8san_pkg;

	typedef enum logic {
		ST_IDLE,
		ST_DRAIN
	} state_t;

	typedef struct packed {
		logic load;
		logic pop;
	} ctrl_cmd_t;

	typedef struct packed {
		logic new_any;
		logic rem_last;
	} dp_stat_t;

	localparam logic [7:0] REPL_RESET   = 8'h3F;
	localparam logic [7:0] ASCII_LIMIT  = 8'h80;
	localparam logic [7:0] LEAD2_LO     = 8'hC2;
	localparam logic [7:0] LEAD2_HI     = 8'hDF;
	localparam logic [7:0] LEAD3_LO     = 8'hE0;
	localparam logic [7:0] LEAD3_HI     = 8'hEF;
	localparam logic [7:0] LEAD4_LO     = 8'hF0;
	localparam logic [7:0] LEAD4_HI     = 8'hF4;
	localparam logic [7:0] CONT_MASK    = 8'hC0;
	localparam logic [7:0] CONT_TAG     = 8'h80;
	localparam logic [7:0] LEAD_E0      = 8'hE0;
	localparam logic [7:0] LEAD_ED      = 8'hED;
	localparam logic [7:0] LEAD_F0      = 8'hF0;
	localparam logic [7:0] LEAD_F4      = 8'hF4;
	localparam logic [7:0] SEC_A0       = 8'hA0;
	localparam logic [7:0] SEC_90       = 8'h90;
	localparam logic [7:0] SEC_8F       = 8'h8F;

	// full sequence length for a multibyte lead byte, zero for any other byte
	function automatic logic [2:0] lead_len(input logic [7:0] b);
		logic [2:0] len;
		len = 3'd0;
		if (b >= LEAD2_LO && b <= LEAD2_HI) begin
			len = 3'd2;
		end else if (b >= LEAD3_LO && b <= LEAD3_HI) begin
			len = 3'd3;
		end else if (b >= LEAD4_LO && b <= LEAD4_HI) begin
			len = 3'd4;
		end
		return len;
	endfunction

	// second byte range limits against overlongs, surrogates and > 10FFFF
	function automatic logic second_ok(input logic [7:0] lead, input logic [7:0] b);
		logic ok;
		ok = 1'b1;
		if (lead == LEAD_E0 && b < SEC_A0) begin
			ok = 1'b0;
		end
		if (lead == LEAD_ED && b >= SEC_A0) begin
			ok = 1'b0;
		end
		if (lead == LEAD_F0 && b < SEC_90) begin
			ok = 1'b0;
		end
		if (lead == LEAD_F4 && b > SEC_8F) begin
			ok = 1'b0;
		end
		return ok;
	endfunction

endpackage

// ===== src/u8san_if.sv =====
// stream channel interfaces for sanitizer input and output
interface u8san_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       end_of_text;

	modport source (output valid, output data_byte, output end_of_text, input ready);
	modport sink (input valid, input data_byte, input end_of_text, output ready);
endinterface

interface u8san_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       out_last;

	modport source (output valid, output out_byte, output out_last, input ready);
	modport sink (input valid, input out_byte, input out_last, output ready);
endinterface

// ===== src/u8san_dp.sv =====
// sanitizer datapath: held sequence, result buffer and replacement register
module u8san_dp (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [7:0]            cfg_data,
	input  logic [7:0]            data_byte,
	input  logic                  end_of_text,
	input  u8san_pkg::ctrl_cmd_t  cmd,
	output u8san_pkg::dp_stat_t   stat,
	output logic [7:0]            out_byte,
	output logic                  out_last
);

	logic [7:0] repl_q;
	logic [7:0] held_q [3];
	logic [1:0] held_cnt_q;
	logic [2:0] seq_len_q;

	logic [7:0] obuf_q [4];
	logic [2:0] rem_q;
	logic       last_q;

	logic [7:0] held_n [3];
	logic [1:0] cnt_n;
	logic [2:0] len_n;
	logic [7:0] lst [4];
	logic [2:0] n;
	logic       ok;
	logic       do_fresh;
	logic [2:0] f_len;

	always_comb begin
		held_n   = held_q;
		cnt_n    = held_cnt_q;
		len_n    = seq_len_q;
		lst      = '{default: '0};
		n        = '0;
		do_fresh = 1'b0;
		f_len    = u8san_pkg::lead_len(data_byte);
		ok       = (data_byte & u8san_pkg::CONT_MASK) == u8san_pkg::CONT_TAG;
		if (held_cnt_q == 2'd1) begin
			ok = ok && u8san_pkg::second_ok(held_q[0], data_byte);
		end

		if (held_cnt_q == 2'd0) begin
			do_fresh = 1'b1;
		end else if (ok) begin
			if ({1'b0, held_cnt_q} + 3'd1 == seq_len_q) begin
				// sequence complete, pass it on unchanged
				for (int i = 0; i < 3; i++) begin
					if (i < int'(held_cnt_q) && n < 3'd4) begin
						lst[n[1:0]] = held_q[i];
						n = n + 3'd1;
					end
				end
				if (n < 3'd4) begin
					lst[n[1:0]] = data_byte;
					n = n + 3'd1;
				end
				cnt_n = '0;
				len_n = '0;
			end else begin
				if (held_cnt_q != 2'd3) begin
					held_n[held_cnt_q] = data_byte;
				end
				cnt_n = held_cnt_q + 2'd1;
			end
		end else begin
			// broken sequence: every held byte turns into a replacement
			for (int i = 0; i < 3; i++) begin
				if (i < int'(held_cnt_q) && n < 3'd4) begin
					lst[n[1:0]] = repl_q;
					n = n + 3'd1;
				end
			end
			cnt_n    = '0;
			len_n    = '0;
			do_fresh = 1'b1;
		end

		if (do_fresh) begin
			if (data_byte < u8san_pkg::ASCII_LIMIT) begin
				if (n < 3'd4) begin
					lst[n[1:0]] = data_byte;
					n = n + 3'd1;
				end
			end else if (f_len == 3'd0) begin
				if (n < 3'd4) begin
					lst[n[1:0]] = repl_q;
					n = n + 3'd1;
				end
			end else begin
				held_n[0] = data_byte;
				cnt_n     = 2'd1;
				len_n     = f_len;
			end
		end

		// cut off at end of text
		if (end_of_text) begin
			for (int i = 0; i < 3; i++) begin
				if (i < int'(cnt_n) && n < 3'd4) begin
					lst[n[1:0]] = repl_q;
					n = n + 3'd1;
				end
			end
			cnt_n = '0;
			len_n = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			repl_q     <= u8san_pkg::REPL_RESET;
			held_cnt_q <= '0;
			seq_len_q  <= '0;
			rem_q      <= '0;
			last_q     <= 1'b0;
		end else begin
			if (cfg_we) begin
				repl_q <= cfg_data;
			end
			if (cmd.load) begin
				held_cnt_q <= cnt_n;
				seq_len_q  <= len_n;
				rem_q      <= n;
				last_q     <= end_of_text;
			end else if (cmd.pop) begin
				rem_q <= rem_q - 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			held_q <= held_n;
			obuf_q <= lst;
		end else if (cmd.pop) begin
			// shift the next result to the head
			obuf_q[0] <= obuf_q[1];
			obuf_q[1] <= obuf_q[2];
			obuf_q[2] <= obuf_q[3];
		end
	end

	assign out_byte      = obuf_q[0];
	assign out_last      = last_q && (rem_q == 3'd1);
	assign stat.new_any  = (n != 3'd0);
	assign stat.rem_last = (rem_q == 3'd1);

endmodule

// ===== src/u8san_ctrl.sv =====
// sanitizer controller: accepts items and drains their results
module u8san_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	output logic                  out_valid,
	input  logic                  out_ready,
	input  u8san_pkg::dp_stat_t   stat,
	output u8san_pkg::ctrl_cmd_t  cmd
);

	u8san_pkg::state_t state_q;
	u8san_pkg::state_t state_n;

	always_comb begin
		state_n = state_q;
		case (state_q)
			u8san_pkg::ST_IDLE: begin
				if (in_valid && stat.new_any) begin
					state_n = u8san_pkg::ST_DRAIN;
				end
			end
			u8san_pkg::ST_DRAIN: begin
				if (out_ready && stat.rem_last) begin
					// next item may load in the same cycle the last result leaves
					if (in_valid && stat.new_any) begin
						state_n = u8san_pkg::ST_DRAIN;
					end else begin
						state_n = u8san_pkg::ST_IDLE;
					end
				end
			end
			default: begin
				state_n = u8san_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		in_ready  = 1'b0;
		out_valid = 1'b0;
		case (state_q)
			u8san_pkg::ST_IDLE: begin
				in_ready = 1'b1;
			end
			u8san_pkg::ST_DRAIN: begin
				out_valid = 1'b1;
				in_ready  = out_ready && stat.rem_last;
			end
			default: begin
				in_ready  = 1'b0;
				out_valid = 1'b0;
			end
		endcase
		cmd.load = in_valid && in_ready;
		cmd.pop  = out_valid && out_ready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= u8san_pkg::ST_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

endmodule

// ===== src/utf8_sanitizer_top.sv =====
// utf8 sanitizer top level: controller plus datapath
// an item is taken on its handshake; its first result is offered the next cycle
// an item with k results offers them in order, one transfer each, held while out_ready is low
// the next item is taken in the cycle of the last result's transfer, so items
// with at most one result run at one per cycle while out_ready is high
// reset empties the held sequence and sets the replacement byte to 0x3F
module utf8_sanitizer_top (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [7:0]        cfg_data,
	u8san_in_if.sink          in_chan,
	u8san_out_if.source       out_chan
);

	u8san_pkg::ctrl_cmd_t cmd;
	u8san_pkg::dp_stat_t  stat;

	u8san_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_chan.valid),
		.in_ready  (in_chan.ready),
		.out_valid (out_chan.valid),
		.out_ready (out_chan.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	u8san_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_data    (cfg_data),
		.data_byte   (in_chan.data_byte),
		.end_of_text (in_chan.end_of_text),
		.cmd         (cmd),
		.stat        (stat),
		.out_byte    (out_chan.out_byte),
		.out_last    (out_chan.out_last)
	);

endmodule
